// ----- design/rbsi_pkg.sv -----
package rbsi_pkg;

	localparam int CoordW = 32;
	localparam int DirW   = 16;
	localparam int OffW   = 33;
	// offset * 2^14 magnitude fits in 33 + 14 bits
	localparam int NumW   = 47;
	localparam int DenW   = 15;
	// quotient magnitude bits; saturates from 2^31 up (positive) or above 2^31 (negative)
	localparam int QW     = 47;
	localparam int NumRegs = 6;
	localparam int AddrW  = 5;

	localparam logic signed [CoordW-1:0] TMaxQ = 32'sh7FFF_FFFF;
	localparam logic signed [CoordW-1:0] TMinQ = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_LO_X = 3'd0,
		REG_LO_Y = 3'd1,
		REG_LO_Z = 3'd2,
		REG_HI_X = 3'd3,
		REG_HI_Y = 3'd4,
		REG_HI_Z = 3'd5
	} reg_idx_t;

	// per-division flags carried beside the divider pipeline
	typedef struct packed {
		logic zero_off;
		logic zero_dir;
		logic neg;
	} div_tag_t;

endpackage

// ----- design/rbsi_div.sv -----
// Pipelined signed divide: (off * 2^14) / dir, truncating, saturated to 32 bits.
// One quotient bit per stage, one item per cycle while adv is high.
module rbsi_div
	import rbsi_pkg::*;
(
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [OffW-1:0]   off,
	input  logic signed [DirW-1:0]   dir,
	output logic signed [CoordW-1:0] t
);

	logic [NumW-1:0]  num_s1;
	logic [DenW:0]    den_s1;
	div_tag_t         tag_s1;

	logic [NumW-1:0]  rem_p [QW+1];
	logic [NumW-1:0]  quo_p [QW+1];
	logic [NumW-1:0]  nsh_p [QW+1];
	logic [DenW:0]    den_p [QW+1];
	div_tag_t         tag_p [QW+1];

	logic [OffW-1:0]  off_mag;
	logic [DenW:0]    dir_mag;

	assign off_mag = off[OffW-1] ? OffW'(-off) : OffW'(off);
	assign dir_mag = dir[DirW-1] ? (DenW+1)'(-dir) : (DenW+1)'(dir);

	// take magnitudes and sign
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= {off_mag[NumW-15:0], 14'd0};
			den_s1 <= dir_mag;
			tag_s1 <= '{zero_off: (off == '0), zero_dir: (dir == '0),
				neg: off[OffW-1] ^ dir[DirW-1]};
		end
	end

	assign rem_p[0] = '0;
	assign quo_p[0] = '0;
	assign nsh_p[0] = num_s1;
	assign den_p[0] = den_s1;
	assign tag_p[0] = tag_s1;

	// restoring division, one bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_bit
		logic [NumW:0]   trial;
		logic [NumW-1:0] rem_s, quo_s, nsh_s;
		logic [DenW:0]   den_s;
		div_tag_t        tag_s;
		assign trial = {rem_p[i], nsh_p[i][NumW-1]} - (NumW+1)'(den_p[i]);
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!trial[NumW]) begin
					rem_s <= trial[NumW-1:0];
					quo_s <= {quo_p[i][NumW-2:0], 1'b1};
				end else begin
					rem_s <= {rem_p[i][NumW-2:0], nsh_p[i][NumW-1]};
					quo_s <= {quo_p[i][NumW-2:0], 1'b0};
				end
				nsh_s <= {nsh_p[i][NumW-2:0], 1'b0};
				den_s <= den_p[i];
				tag_s <= tag_p[i];
			end
		end
		assign rem_p[i+1] = rem_s;
		assign quo_p[i+1] = quo_s;
		assign nsh_p[i+1] = nsh_s;
		assign den_p[i+1] = den_s;
		assign tag_p[i+1] = tag_s;
	end

	logic        big_pos, big_neg;
	div_tag_t    tg;
	logic [NumW-1:0] q;

	assign q  = quo_p[QW];
	assign tg = tag_p[QW];
	assign big_pos = (q[NumW-1:31] != '0);
	assign big_neg = (q[NumW-1:31] != '0) && (q != (NumW'(1) << 31));

	// apply special cases and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			if (tg.zero_off)
				t <= '0;
			else if (tg.zero_dir)
				t <= tg.neg ? TMinQ : TMaxQ;
			else if (tg.neg)
				t <= big_neg ? TMinQ : CoordW'(-q);
			else
				t <= big_pos ? TMaxQ : CoordW'(q);
		end
	end

	// Zero direction with nonzero dividend: dir of zero gives neg from off sign only
	// since dir sign bit is 0.

endmodule

// ----- design/rbsi_reduce.sv -----
// Orders per-axis entry/exit, reduces over axes, checks overlap. Two stages.
module rbsi_reduce
	import rbsi_pkg::*;
(
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [CoordW-1:0] lo [3],
	input  logic signed [CoordW-1:0] hi [3],
	input  logic signed [CoordW-1:0] t_min,
	input  logic signed [CoordW-1:0] t_max,
	output logic                     hit,
	output logic signed [CoordW-1:0] near_t,
	output logic signed [CoordW-1:0] far_t
);

	logic signed [CoordW-1:0] en [3], ex [3];
	logic signed [CoordW-1:0] n01, f01, n_s1, f_s1;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			en[a] = (lo[a] < hi[a]) ? lo[a] : hi[a];
			ex[a] = (lo[a] < hi[a]) ? hi[a] : lo[a];
		end
		n01 = (en[1] > en[0]) ? en[1] : en[0];
		f01 = (ex[1] < ex[0]) ? ex[1] : ex[0];
	end

	// reduce over the three axes
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= (en[2] > n01) ? en[2] : n01;
			f_s1 <= (ex[2] < f01) ? ex[2] : f01;
		end
	end

	// test overlap with the ray interval
	always_ff @(posedge clk) begin
		if (adv) begin
			near_t <= n_s1;
			far_t  <= f_s1;
			hit    <= (f_s1 >= n_s1) && (f_s1 >= t_min) && (n_s1 <= t_max);
		end
	end

endmodule

// ----- design/ray_box_slab_intersect.sv -----
// Slab test of a ray against the box held in six APB registers (Q16.16, byte
// address 4*i). One ray is accepted every cycle while the output is not stalled;
// each result passes through the face-offset register and the bit-per-stage
// divider pipeline (six dividers in parallel, one per face) before the reduction.
// A stalled output holds the entire pipeline.
module ray_box_slab_intersect
	import rbsi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [AddrW-1:0]         paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CoordW-1:0] origin_x,
	input  logic signed [CoordW-1:0] origin_y,
	input  logic signed [CoordW-1:0] origin_z,
	input  logic signed [DirW-1:0]   dir_x,
	input  logic signed [DirW-1:0]   dir_y,
	input  logic signed [DirW-1:0]   dir_z,
	input  logic signed [CoordW-1:0] ray_t_min,
	input  logic signed [CoordW-1:0] ray_t_max,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [CoordW-1:0] near_t,
	output logic signed [CoordW-1:0] far_t
);

	localparam int Lat = QW + 5;

	logic signed [CoordW-1:0] box_q [NumRegs];
	logic                     adv;
	logic [Lat-1:0]           vld_q;
	logic signed [OffW-1:0]   off_s0 [6];
	logic signed [DirW-1:0]   dir_s0 [6];
	logic signed [CoordW-1:0] par [6];
	logic signed [CoordW-1:0] lo_t [3], hi_t [3];
	logic signed [CoordW-1:0] tmin_p [Lat-1], tmax_p [Lat-1];
	logic signed [CoordW-1:0] org [3];
	logic signed [DirW-1:0]   dr [3];
	logic [2:0]               ridx;

	assign pready   = 1'b1;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[Lat-1];
	assign ridx     = paddr[AddrW-1:2];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) box_q[i] <= '0;
		end else if (psel && penable && pwrite && paddr[AddrW-1:2] < 3'(NumRegs)) begin
			box_q[ridx] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (ridx < 3'(NumRegs)) prdata = box_q[ridx];
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[Lat-2:0], in_valid};
	end

	assign org = '{origin_x, origin_y, origin_z};
	assign dr  = '{dir_x, dir_y, dir_z};

	// face offsets, registered before the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				off_s0[a]   <= OffW'(box_q[a]) - OffW'(org[a]);
				off_s0[a+3] <= OffW'(box_q[a+3]) - OffW'(org[a]);
				dir_s0[a]   <= dr[a];
				dir_s0[a+3] <= dr[a];
			end
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_div
		rbsi_div u_div (.clk, .adv, .off(off_s0[k]), .dir(dir_s0[k]), .t(par[k]));
	end

	assign lo_t = '{par[0], par[1], par[2]};
	assign hi_t = '{par[3], par[4], par[5]};

	// carry the ray interval alongside
	always_ff @(posedge clk) begin
		if (adv) begin
			tmin_p[0] <= ray_t_min;
			tmax_p[0] <= ray_t_max;
			for (int i = 1; i < Lat-1; i++) begin
				tmin_p[i] <= tmin_p[i-1];
				tmax_p[i] <= tmax_p[i-1];
			end
		end
	end

	rbsi_reduce u_red (
		.clk, .adv, .lo(lo_t), .hi(hi_t),
		.t_min(tmin_p[Lat-2]), .t_max(tmax_p[Lat-2]),
		.hit, .near_t, .far_t
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(near_t) && $stable(far_t))
		else $error("result changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##1 vld_q[0])
		else $error("accepted request lost");

endmodule

// ----- dv/ray_box_slab_checker.sv -----
`timescale 1ns / 100ps

module ray_box_slab_checker
	import rbsi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [AddrW-1:0]         paddr,
	input  logic [31:0]              pwdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [CoordW-1:0] origin_x,
	input  logic signed [CoordW-1:0] origin_y,
	input  logic signed [CoordW-1:0] origin_z,
	input  logic signed [DirW-1:0]   dir_x,
	input  logic signed [DirW-1:0]   dir_y,
	input  logic signed [DirW-1:0]   dir_z,
	input  logic signed [CoordW-1:0] ray_t_min,
	input  logic signed [CoordW-1:0] ray_t_max,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     hit,
	input  logic signed [CoordW-1:0] near_t,
	input  logic signed [CoordW-1:0] far_t,
	output int                       fail_count,
	output int                       pending
);

	typedef struct {
		logic                     hit;
		logic signed [CoordW-1:0] near_t;
		logic signed [CoordW-1:0] far_t;
	} span_t;

	logic signed [CoordW-1:0] box_face [NumRegs];
	span_t span_q[$];

	assign pending = span_q.size();

	// slab parameter: (offset << 14) / dir, truncated and saturated
	function automatic longint slab_t(longint off, longint dv);
		longint q;
		if (off == 0)
			return 0;
		if (dv == 0)
			return (off > 0) ? 64'sd2147483647 : -64'sd2147483648;
		q = (off * 16384) / dv;
		if (q > 64'sd2147483647)
			return 64'sd2147483647;
		if (q < -64'sd2147483648)
			return -64'sd2147483648;
		return q;
	endfunction

	function automatic span_t predict_span();
		longint org [3];
		longint dv [3];
		longint lo, hi, ent, ext, nq, fq;
		span_t s;
		org[0] = origin_x; org[1] = origin_y; org[2] = origin_z;
		dv[0] = dir_x; dv[1] = dir_y; dv[2] = dir_z;
		nq = 0;
		fq = 0;
		for (int a = 0; a < 3; a++) begin
			lo = slab_t(longint'(box_face[a]) - org[a], dv[a]);
			hi = slab_t(longint'(box_face[a+3]) - org[a], dv[a]);
			ent = (lo < hi) ? lo : hi;
			ext = (lo < hi) ? hi : lo;
			if (a == 0 || ent > nq)
				nq = ent;
			if (a == 0 || ext < fq)
				fq = ext;
		end
		s.hit = (fq >= nq) && (fq >= longint'(ray_t_min)) && (nq <= longint'(ray_t_max));
		s.near_t = nq[31:0];
		s.far_t = fq[31:0];
		return s;
	endfunction

	// track registers, predict each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		span_t e;
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++)
				box_face[i] <= '0;
			span_q.delete();
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				span_q.push_back(predict_span());
			if (out_valid && !out_stall) begin
				if (span_q.size() == 0) begin
					$error("unexpected result hit=%0b near_t=%0d far_t=%0d", hit, near_t, far_t);
					fail_count <= fail_count + 1;
				end else begin
					e = span_q.pop_front();
					if (hit !== e.hit || near_t !== e.near_t || far_t !== e.far_t)
						fail_count <= fail_count + 1;
					if (hit !== e.hit)
						$error("hit: expected %0b actual %0b", e.hit, hit);
					if (near_t !== e.near_t)
						$error("near_t: expected %0d actual %0d", e.near_t, near_t);
					if (far_t !== e.far_t)
						$error("far_t: expected %0d actual %0d", e.far_t, far_t);
				end
			end
			if (psel && penable && pwrite && pready && paddr[AddrW-1:2] < 3'(NumRegs))
				box_face[paddr[AddrW-1:2]] <= pwdata;
		end
	end

endmodule

// ----- dv/ray_box_slab_intersect_tb.sv -----
`timescale 1ns / 100ps

module ray_box_slab_intersect_tb;
	import rbsi_pkg::*;

	localparam int Latency = 60;
	localparam int IdleLimit = 4000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CoordW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [DirW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [CoordW-1:0] ray_t_min = '0, ray_t_max = '0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	logic signed [CoordW-1:0] near_t, far_t;
	int fail_count, pending;
	int idle_cycles = 0;
	int stall_mode = 0;

	always #6 clk = ~clk;

	ray_box_slab_intersect dut (.*);
	ray_box_slab_checker chk (.*);

	// stall the result side on a pattern that shifts between modes
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	// watchdog on cycles with no request and no result moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_box(input reg_idx_t idx, input logic [31:0] val);
		paddr <= AddrW'(idx) << 2;
		pwdata <= val;
		psel <= 1;
		pwrite <= 1;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (Latency) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic logic [15:0] rand_dir();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return $urandom_range(0, 3) - 1;
			default: return $urandom;
		endcase
	endfunction

	// present one request and hold it until accepted
	task automatic send_ray(input logic [31:0] ox, oy, oz, input logic [15:0] dx, dy, dz,
			input logic [31:0] tmin, tmax);
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		ray_t_min <= tmin; ray_t_max <= tmax;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		send_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir(),
			($urandom_range(0, 3) == 0) ? $urandom : 32'h8000_0000 + $urandom_range(0, 1),
			($urandom_range(0, 3) == 0) ? $urandom : 32'h7FFF_FFFF - $urandom_range(0, 1));
	endtask

	task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
		write_box(REG_LO_X, lx);
		write_box(REG_LO_Y, ly);
		write_box(REG_LO_Z, lz);
		write_box(REG_HI_X, hx);
		write_box(REG_HI_Y, hy);
		write_box(REG_HI_Z, hz);
	endtask

	initial begin
		int burst;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// unit box, directed rays
		set_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_ray(32'hFFFB_0000, 0, 0, 16'h4000, 16'h4000, 16'h4000,
			32'h8000_0000, 32'h7FFF_FFFF);
		send_ray(32'hFFFB_0000, 32'h0000_8000, 0, 16'h4000, 0, 0,
			0, 32'h7FFF_FFFF);
		send_ray(32'hFFFB_0000, 32'h0005_0000, 0, 16'h4000, 0, 0,
			0, 32'h7FFF_FFFF);
		send_ray(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0,
			0, 0);
		send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 16'hFFFF, 16'h8000,
			32'h8000_0000, 32'h7FFF_FFFF);
		send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h0001,
			32'h7FFF_FFFF, 32'h8000_0000);
		send_ray(0, 0, 0, 16'hFFFF, 16'h0001, 16'h7FFF, 32'h0010_0000, 32'h0020_0000);
		send_ray(32'h0003_0000, 0, 0, 16'hC000, 16'h1000, 16'h2000, 0, 32'h0001_0000);
		send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		in_valid <= 0;
		drain();

		// extreme and inverted boxes
		set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_ray(0, 0, 0, 16'h0001, 16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF, 16'h0001, 0, 0, 0);
		in_valid <= 0;
		drain();
		set_box(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
			32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000);
		send_ray(32'hFFF0_0000, 0, 0, 16'h4000, 16'h0100, 16'hF000, 0, 32'h7FFF_FFFF);
		send_ray(0, 0, 0, 0, 0, 0, 0, 0);
		in_valid <= 0;
		drain();

		// random phases with bursts and gaps
		for (int phase = 0; phase < 7; phase++) begin
			set_box(rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord());
			for (int n = 0; n < 100; n += burst) begin
				burst = $urandom_range(1, 20);
				for (int k = 0; k < burst; k++)
					send_random();
				in_valid <= 0;
				if ($urandom_range(0, 5) == 0)
					while (pending != 0)
						@(negedge clk);
				else
					repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
